[src/eti_pkg.sv]
// ----------------------------------------------------------------------------
// eti_pkg
// Shared constants and types for the escape-time iteration block.
// ----------------------------------------------------------------------------
package eti_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_CELLS_DEF   = 4;
    localparam int INT_BITS        = 6;
    localparam int CFG_ADDR_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam logic [15:0] MAX_ITER_RESET = 16'd200;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_MAX_ITERATIONS = 3'd0,
        REG_JULIA_MODE     = 3'd1,
        REG_JULIA_REAL     = 3'd2,
        REG_JULIA_IMAG     = 3'd3,
        REG_BOUND_SHAPE    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } eti_state_t;

endpackage

[src/eti_cell.sv]
// ----------------------------------------------------------------------------
// eti_cell
// One iteration cell: tests z for escape and advances it by one update step.
// Squares and cross product are registered; the next cell sees updated z.
// ----------------------------------------------------------------------------
module eti_cell
    import eti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic                          in_done,
    input  logic        [COUNT_WIDTH-1:0] in_step,
    input  logic signed [COORD_WIDTH-1:0] in_re,
    input  logic signed [COORD_WIDTH-1:0] in_im,
    input  logic signed [COORD_WIDTH-1:0] shift_re,
    input  logic signed [COORD_WIDTH-1:0] shift_im,
    input  logic        [COUNT_WIDTH-1:0] limit,
    input  logic                          bound_shape,
    output logic                          out_valid,
    output logic                          out_done,
    output logic        [COUNT_WIDTH-1:0] out_step,
    output logic signed [COORD_WIDTH-1:0] out_re,
    output logic signed [COORD_WIDTH-1:0] out_im
);

    localparam int FRAC = COORD_WIDTH - INT_BITS;
    localparam int PW   = 2 * COORD_WIDTH;
    localparam int SW   = PW + 2;

    // stage 1: magnitudes and products
    logic [COORD_WIDTH-1:0] mag_a, mag_b;
    logic [COORD_WIDTH:0]   sum_ab;
    logic [PW-1:0]          aa_next, bb_next, ab_next;
    logic [PW+1:0]          ss_next;

    assign mag_a  = in_re[COORD_WIDTH-1] ? COORD_WIDTH'(-in_re) : COORD_WIDTH'(in_re);
    assign mag_b  = in_im[COORD_WIDTH-1] ? COORD_WIDTH'(-in_im) : COORD_WIDTH'(in_im);
    assign sum_ab = {1'b0, mag_a} + {1'b0, mag_b};
    assign aa_next = PW'(mag_a) * PW'(mag_a);
    assign bb_next = PW'(mag_b) * PW'(mag_b);
    assign ab_next = PW'(mag_a) * PW'(mag_b);
    assign ss_next = (PW+2)'(sum_ab) * (PW+2)'(sum_ab);

    logic                   s1_valid_reg, s1_done_reg, s1_neg_reg, s1_big_reg;
    logic [COUNT_WIDTH-1:0] s1_step_reg;
    logic [PW-1:0]          aa_reg, bb_reg, ab_reg;
    logic [PW+1:0]          ss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        s1_done_reg <= in_done || (in_step >= limit);
        s1_step_reg <= in_step;
        s1_neg_reg  <= in_re[COORD_WIDTH-1] ^ in_im[COORD_WIDTH-1];
        s1_big_reg  <= sum_ab > (COORD_WIDTH+1)'(1) << (FRAC + 2);
        aa_reg      <= aa_next;
        bb_reg      <= bb_next;
        ab_reg      <= ab_next;
        ss_reg      <= ss_next;
    end

    // stage 2: escape test, rescale, add shift, saturate
    logic            esc;
    logic [PW:0]     norm;
    logic            dneg;
    logic [PW-1:0]   dmag, ppos;
    logic [PW:0]     rnd_d, rnd_p;
    logic signed [SW-1:0] nr, ni, sr, si;
    logic signed [SW-1:0] hi_lim, lo_lim;

    assign norm = {1'b0, aa_reg} + {1'b0, bb_reg};
    assign esc  = bound_shape
                ? (s1_big_reg || ss_reg > (PW+2)'(1) << (2*FRAC + 3))
                : (norm > (PW+1)'(1) << (2*FRAC + 2));
    assign dneg = bb_reg > aa_reg;
    assign dmag = dneg ? bb_reg - aa_reg : aa_reg - bb_reg;
    assign rnd_d = dneg ? ({1'b0, dmag} + (((PW+1)'(1) << FRAC) - 1'b1)) : {1'b0, dmag};
    assign ppos = ab_reg;
    assign rnd_p = (s1_neg_reg && ppos != '0)
                 ? ({1'b0, ppos} + (((PW+1)'(1) << (FRAC-1)) - 1'b1)) : {1'b0, ppos};
    always_comb begin
        nr = SW'(rnd_d >> FRAC);
        if (dneg) nr = -nr;
        ni = SW'(rnd_p >> (FRAC-1));
        if (s1_neg_reg && ppos != '0) ni = -ni;
    end
    assign sr = nr + SW'(shift_re);
    assign si = ni + SW'(shift_im);
    assign hi_lim = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    assign lo_lim = -hi_lim - SW'(1);

    logic                          ov_reg, od_reg;
    logic        [COUNT_WIDTH-1:0] os_reg;
    logic signed [COORD_WIDTH-1:0] ore_reg, oim_reg;
    logic                          stop;
    assign stop = s1_done_reg || esc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= s1_valid_reg;
        end
        od_reg <= stop;
        os_reg <= stop ? s1_step_reg : s1_step_reg + 1'b1;
        ore_reg <= (sr > hi_lim) ? hi_lim[COORD_WIDTH-1:0]
                 : (sr < lo_lim) ? lo_lim[COORD_WIDTH-1:0] : sr[COORD_WIDTH-1:0];
        oim_reg <= (si > hi_lim) ? hi_lim[COORD_WIDTH-1:0]
                 : (si < lo_lim) ? lo_lim[COORD_WIDTH-1:0] : si[COORD_WIDTH-1:0];
    end

    assign out_valid = ov_reg;
    assign out_done  = od_reg;
    assign out_step  = os_reg;
    assign out_re    = ore_reg;
    assign out_im    = oim_reg;

endmodule

[src/escape_time_iteration.sv]
// ----------------------------------------------------------------------------
// escape_time_iteration
// Mandelbrot / Julia escape-time counter over a ring of iteration cells.
// ----------------------------------------------------------------------------
// One point is iterated at a time. It circulates through a ring of NUM_CELLS
// cells, each doing one escape test and one z = z*z + shift update in two
// register stages, and a point reaches the tail after
// ceil((escape_count+1)/NUM_CELLS) laps of the ring. The next point can be
// taken in the same cycle as the result appears. The result register holds a
// finished count while the next point runs; if it is still held when the next
// point finishes, that point keeps circulating until the register is free and
// then leaves at the tail.
module escape_time_iteration
    import eti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int NUM_CELLS   = NUM_CELLS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*COORD_WIDTH-1:0]    s_tdata,   // point_real, point_imag
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((COUNT_WIDTH+7)/8)*8-1:0] m_tdata, // escape_count
    input  logic                        cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata
);

    localparam int OUTW = ((COUNT_WIDTH+7)/8)*8;

    logic [15:0]                   max_iter_reg;
    logic                          julia_mode_reg, bound_shape_reg;
    logic signed [COORD_WIDTH-1:0] julia_re_reg, julia_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg    <= MAX_ITER_RESET;
            julia_mode_reg  <= 1'b0;
            julia_re_reg    <= '0;
            julia_im_reg    <= '0;
            bound_shape_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAX_ITERATIONS: max_iter_reg    <= cfg_wdata[15:0];
                REG_JULIA_MODE:     julia_mode_reg  <= cfg_wdata[0];
                REG_JULIA_REAL:     julia_re_reg    <= COORD_WIDTH'(signed'(cfg_wdata));
                REG_JULIA_IMAG:     julia_im_reg    <= COORD_WIDTH'(signed'(cfg_wdata));
                REG_BOUND_SHAPE:    bound_shape_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [COUNT_WIDTH-1:0] limit;
    assign limit = COUNT_WIDTH'(max_iter_reg);

    eti_state_t state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] sh_re_reg, sh_im_reg;
    logic [COUNT_WIDTH-1:0] res_reg;
    logic                   m_valid_reg;

    logic                          cv [NUM_CELLS+1];
    logic                          cd [NUM_CELLS+1];
    logic        [COUNT_WIDTH-1:0] cs [NUM_CELLS+1];
    logic signed [COORD_WIDTH-1:0] cre [NUM_CELLS+1];
    logic signed [COORD_WIDTH-1:0] cim [NUM_CELLS+1];

    logic accept, finish, out_free;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = cv[NUM_CELLS] && cd[NUM_CELLS] && out_free;

    // feed: new point on accept, else recirculate the tail until it can leave
    assign cv[0]  = accept || (cv[NUM_CELLS] && !finish);
    assign cd[0]  = accept ? 1'b0 : cd[NUM_CELLS];
    assign cs[0]  = accept ? '0 : cs[NUM_CELLS];
    assign cre[0] = accept ? s_tdata[COORD_WIDTH-1:0] : cre[NUM_CELLS];
    assign cim[0] = accept ? s_tdata[2*COORD_WIDTH-1:COORD_WIDTH] : cim[NUM_CELLS];

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        eti_cell #(.COORD_WIDTH(COORD_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(cv[g]), .in_done(cd[g]), .in_step(cs[g]),
            .in_re(cre[g]), .in_im(cim[g]),
            .shift_re(sh_re_reg), .shift_im(sh_im_reg),
            .limit(limit), .bound_shape(bound_shape_reg),
            .out_valid(cv[g+1]), .out_done(cd[g+1]), .out_step(cs[g+1]),
            .out_re(cre[g+1]), .out_im(cim[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_RUN;
            ST_RUN:  if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata  = OUTW'(res_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            sh_re_reg <= julia_mode_reg ? julia_re_reg : s_tdata[COORD_WIDTH-1:0];
            sh_im_reg <= julia_mode_reg ? julia_im_reg
                                        : s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end
        if (finish) res_reg <= cs[NUM_CELLS];
    end

endmodule

[bench/tb_escape_time_iteration.sv]
// ----------------------------------------------------------------------------
// tb_escape_time_iteration
// Self-checking bench for the escape-time counter: predicts the escape count
// per point in fixed point, checks every result transfer in order, and walks
// through several register settings, mostly with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_escape_time_iteration
    import eti_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 500000;
    localparam logic signed [31:0] ONE = 32'sd67108864;

    typedef struct packed {
        logic [31:0] im;
        logic [31:0] re;
    } point_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [63:0]               s_tdata;   // point_real, point_imag
    logic                      m_tvalid;
    logic                      m_tready;
    logic [15:0]               m_tdata;   // escape_count
    logic                      cfg_we;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

    point_t      point_queue[$];
    logic [15:0] count_queue[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          calm = 0;
    int          send_gap = 0;
    int          recv_gap = 0;

    logic [15:0]        max_iter_q = 16'd200;
    logic               julia_q = 1'b0;
    logic signed [31:0] jre_q = '0;
    logic signed [31:0] jim_q = '0;
    logic               square_q = 1'b0;

    escape_time_iteration DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [15:0] escape_steps(logic signed [31:0] cre,
                                                 logic signed [31:0] cim);
        logic signed [63:0] zr, zi, sr, si, nr, ni;
        logic [63:0]  a, b;
        logic [127:0] aa, bb, d, p, q, sum;
        logic         dneg, pneg, out;
        int unsigned  step;
        zr = cre;
        zi = cim;
        sr = julia_q ? 64'(jre_q) : zr;
        si = julia_q ? 64'(jim_q) : zi;
        for (step = 0; step < max_iter_q; step++) begin
            a = zr < 0 ? -zr : zr;
            b = zi < 0 ? -zi : zi;
            aa = 128'(a) * 128'(a);
            bb = 128'(b) * 128'(b);
            if (!square_q) begin
                out = (aa + bb) > (128'd1 << 54);
            end else begin
                sum = 128'(a) + 128'(b);
                out = (sum > (128'd1 << 28)) || (sum * sum > (128'd1 << 55));
            end
            if (out) break;
            dneg = bb > aa;
            d = dneg ? bb - aa : aa - bb;
            q = dneg ? (d + ((128'd1 << 26) - 1)) >> 26 : d >> 26;
            nr = dneg ? -$signed(q[63:0]) : $signed(q[63:0]);
            p = 128'(a) * 128'(b);
            pneg = ((zr < 0) != (zi < 0)) && (p != 0);
            q = pneg ? (p + ((128'd1 << 25) - 1)) >> 25 : p >> 25;
            ni = pneg ? -$signed(q[63:0]) : $signed(q[63:0]);
            nr = nr + sr;
            ni = ni + si;
            zr = nr > 64'sd2147483647 ? 64'sd2147483647 :
                 nr < -64'sd2147483648 ? -64'sd2147483648 : nr;
            zi = ni > 64'sd2147483647 ? 64'sd2147483647 :
                 ni < -64'sd2147483648 ? -64'sd2147483648 : ni;
        end
        return step[15:0];
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            count_queue.push_back(escape_steps(point_queue[0].re, point_queue[0].im));
            void'(point_queue.pop_front());
            send_gap = calm ? 0 : $urandom_range(0, 13);
            if (send_gap == 0 && point_queue.size() > 0) begin
                s_tdata <= point_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (point_queue.size() > 0) begin
                s_tdata  <= point_queue[0];
                s_tvalid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (count_queue.size() == 0) begin
                $error("escape_count: no result expected, actual %0d", m_tdata);
                errors++;
            end else begin
                if (m_tdata !== count_queue[0]) begin
                    $error("escape_count: expected %0d, actual %0d", count_queue[0], m_tdata);
                    errors++;
                end
                void'(count_queue.pop_front());
            end
            recv_gap = calm ? 0 : $urandom_range(0, 13);
            if (recv_gap > 0) m_tready <= 1'b0;
        end else if (!m_tready) begin
            if (recv_gap > 0) recv_gap--;
            else m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_MAX_ITERATIONS: max_iter_q = value[15:0];
            REG_JULIA_MODE:     julia_q    = value[0];
            REG_JULIA_REAL:     jre_q      = value;
            REG_JULIA_IMAG:     jim_q      = value;
            default:            square_q   = value[0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (point_queue.size() == 0 && count_queue.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_point(logic signed [31:0] re, logic signed [31:0] im);
        point_queue.push_back('{im: im, re: re});
    endtask

    function automatic logic [31:0] near_coord();
        return $urandom_range(5 * 67108864, 0) - 32'd167772160;
    endfunction

    initial begin
        int phase;
        aresetn   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        add_point(0, 0);
        add_point(-2 * ONE, 0);
        add_point(2 * ONE, 0);
        add_point(32'h80000000, 32'h80000000);
        add_point(32'h7FFFFFFF, 32'h7FFFFFFF);
        add_point(32'h7FFFFFFF, 32'h80000000);
        add_point(-ONE, ONE / 4);
        add_point(ONE / 4, ONE / 2);
        add_point(-ONE * 3 / 4, ONE / 8);
        add_point(32'hFFFFFFFF, 32'h00000001);
        drain();

        write_reg(REG_MAX_ITERATIONS, 0);
        add_point(32'h7FFFFFFF, 0);
        add_point(0, 0);
        drain();
        write_reg(REG_MAX_ITERATIONS, 1);
        add_point(32'h80000000, 0);
        add_point(0, 0);
        drain();

        write_reg(REG_MAX_ITERATIONS, 40);
        write_reg(REG_BOUND_SHAPE, 1);
        add_point(2 * ONE, 0);
        add_point(ONE * 2, ONE * 2);
        add_point(-ONE / 2, ONE / 2);
        drain();
        write_reg(REG_JULIA_MODE, 1);
        write_reg(REG_JULIA_REAL, 32'h80000000);
        write_reg(REG_JULIA_IMAG, 32'h7FFFFFFF);
        add_point(0, 0);
        add_point(ONE, -ONE);
        drain();

        write_reg(REG_JULIA_MODE, 0);
        write_reg(REG_BOUND_SHAPE, 0);
        write_reg(REG_MAX_ITERATIONS, 16'hFFFF);
        calm = 1;
        add_point(0, 0);
        add_point(ONE, ONE);
        drain();

        for (phase = 0; phase < 12; phase++) begin
            calm = (phase % 4 == 3);
            write_reg(REG_MAX_ITERATIONS, (phase % 5 == 4) ? $urandom_range(300, 1)
                                                          : $urandom_range(48, 1));
            write_reg(REG_JULIA_MODE, $urandom_range(1, 0));
            write_reg(REG_JULIA_REAL, (phase % 3 == 0) ? $urandom : near_coord() >>> 1);
            write_reg(REG_JULIA_IMAG, (phase % 3 == 0) ? $urandom : near_coord() >>> 1);
            write_reg(REG_BOUND_SHAPE, $urandom_range(1, 0));
            repeat (48) begin
                if ($urandom_range(9, 0) == 0) add_point($urandom, $urandom);
                else add_point(near_coord(), near_coord());
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
src/eti_pkg.sv
src/eti_cell.sv
src/escape_time_iteration.sv
bench/tb_escape_time_iteration.sv
